@@ rtl/am_sample_generator_defines.svh @@
`ifndef AM_SAMPLE_GENERATOR_DEFINES_SVH
`define AM_SAMPLE_GENERATOR_DEFINES_SVH

// check a property on every edge outside reset
`define AMSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication in the next cycle, outside reset
`define AMSG_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/amsg_pkg.sv @@
package amsg_pkg;

    localparam int COS_TABLE_DEPTH = 1024;
    localparam int PHASE_WIDTH     = 32;

    localparam int COS_ADDR_W = $clog2(COS_TABLE_DEPTH);
    localparam int QTR_DEPTH  = COS_TABLE_DEPTH / 4;
    localparam int QTR_ADDR_W = COS_ADDR_W - 2;

    localparam int COS_W      = 16;
    localparam int STEP_W     = 32;
    localparam int AMP_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PH_ADDR_W  = 1;
    localparam int PH_DEPTH   = 2;

    localparam logic [PH_ADDR_W-1:0] PH_CAR = 1'b0;
    localparam logic [PH_ADDR_W-1:0] PH_MOD = 1'b1;

    localparam logic [STEP_W-1:0] CARRIER_STEP_RST = 32'd214748365;
    localparam logic [STEP_W-1:0] MOD_STEP_RST     = 32'd21474836;
    localparam logic [AMP_W-1:0]  CARRIER_AMP_RST  = 15'd16384;
    localparam logic [AMP_W-1:0]  MOD_AMP_RST      = 15'd14746;
    localparam logic [GAIN_W-1:0] OUT_GAIN_RST     = 16'd11382;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CARRIER_STEP,
        REG_MOD_STEP,
        REG_CARRIER_AMP,
        REG_MOD_AMP,
        REG_OUT_GAIN
    } reg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0] carrier_step;
        logic [STEP_W-1:0] mod_step;
        logic [AMP_W-1:0]  carrier_amp;
        logic [AMP_W-1:0]  mod_amp;
        logic [GAIN_W-1:0] out_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAR,
        ST_MOD,
        ST_MULM,
        ST_MULS,
        ST_SCALE
    } state_t;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] ANGLE_DIV = 64'(2 * COS_TABLE_DEPTH);
    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef logic signed [COS_W-1:0] cos_qtr_t [QTR_DEPTH];

    // cosine magnitude times 32767 for a folded angle p in [0, depth]
    function automatic logic signed [COS_W-1:0] cos_mag(input logic [63:0] p);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        int                 i;
        x    = (PI_Q30 * p) / ANGLE_DIV;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = signed'(ONE_Q30);
        for (i = 1; i <= 10; i++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
            if (i[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        mag = ((unsigned'(sum) * 64'd32767) + (ONE_Q30 >> 1)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return signed'(COS_W'(mag));
    endfunction

    function automatic cos_qtr_t build_cos_qtr();
        cos_qtr_t t;
        int       q;
        for (q = 0; q < QTR_DEPTH; q++)
        begin
            t[q] = cos_mag(64'(4 * q));
        end
        return t;
    endfunction

    localparam cos_qtr_t COS_QTR = build_cos_qtr();
    localparam logic signed [COS_W-1:0] COS_QTR_END = cos_mag(64'(COS_TABLE_DEPTH));

endpackage

@@ rtl/amsg_in_if.sv @@
interface amsg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/amsg_out_if.sv @@
interface amsg_out_if;
    import amsg_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;

    modport source (output valid, output sample, output clipped, input ready);
    modport sink (input valid, input sample, input clipped, output ready);
endinterface

@@ rtl/amsg_cfg_if.sv @@
interface amsg_cfg_if;
    import amsg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/am_sample_generator.sv @@
// channel | dir | handshake        | payload
// cmd     | in  | valid / ready    | restart
// smp     | out | valid / ready    | sample[15:0], clipped
// cfg     | in  | valid / ready    | index[2:0], data[31:0]
//
// Each item steps through: accept, carrier phase read-modify-write, modulator phase
// read-modify-write, modulation multiply, AM product, gain scale into the output register.
// The two phases share one single-port-write RAM, read and written on successive cycles.
// Reset clears the FSM, the output valid and the phase valid bits; phases read as zero
// until first written. A held output stalls the scale step; no new item is taken meanwhile.
// cfg is always ready; write it only while no item is in flight.
module am_sample_generator (
    input  logic    clk,
    input  logic    rst_n,
    amsg_in_if.sink     cmd,
    amsg_out_if.source  smp,
    amsg_cfg_if.sink    cfg
);
    import amsg_pkg::*;

    cfg_t regs;

    amsg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    amsg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cmd   (cmd),
        .smp   (smp)
    );
endmodule

@@ rtl/amsg_ram.sv @@
module amsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/amsg_cfg_regs.sv @@
module amsg_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    amsg_cfg_if.sink        cfg,
    output amsg_pkg::cfg_t  regs
);
    import amsg_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_CARRIER_STEP: regs_next.carrier_step = cfg.data[STEP_W-1:0];
                REG_MOD_STEP:     regs_next.mod_step     = cfg.data[STEP_W-1:0];
                REG_CARRIER_AMP:  regs_next.carrier_amp  = cfg.data[AMP_W-1:0];
                REG_MOD_AMP:      regs_next.mod_amp      = cfg.data[AMP_W-1:0];
                REG_OUT_GAIN:     regs_next.out_gain     = cfg.data[GAIN_W-1:0];
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.carrier_step <= CARRIER_STEP_RST;
            regs_reg.mod_step     <= MOD_STEP_RST;
            regs_reg.carrier_amp  <= CARRIER_AMP_RST;
            regs_reg.mod_amp      <= MOD_AMP_RST;
            regs_reg.out_gain     <= OUT_GAIN_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;
endmodule

@@ rtl/amsg_core.sv @@
`include "am_sample_generator_defines.svh"

module amsg_core (
    input  logic           clk,
    input  logic           rst_n,
    input  amsg_pkg::cfg_t regs,
    amsg_in_if.sink        cmd,
    amsg_out_if.source     smp
);
    import amsg_pkg::*;

    localparam logic [COS_ADDR_W-1:0] HALF_TURN = COS_ADDR_W'(COS_TABLE_DEPTH / 2);
    localparam logic [COS_ADDR_W-1:0] QTR_TURN  = COS_ADDR_W'(COS_TABLE_DEPTH / 4);

    function automatic logic signed [COS_W-1:0] cos_lookup(
        input logic [COS_ADDR_W-1:0] k
    );
        logic [COS_ADDR_W-1:0]   k1;
        logic [COS_ADDR_W-1:0]   q;
        logic                    neg;
        logic signed [COS_W-1:0] mag;
        k1 = (k > HALF_TURN) ? (COS_ADDR_W'(0) - k) : k;
        if (k1 > QTR_TURN)
        begin
            q   = HALF_TURN - k1;
            neg = 1'b1;
        end
        else
        begin
            q   = k1;
            neg = 1'b0;
        end
        if (q == QTR_TURN)
            mag = COS_QTR_END;
        else
            mag = COS_QTR[q[QTR_ADDR_W-1:0]];
        return neg ? -mag : mag;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic                    restart_reg;
    logic [PH_DEPTH-1:0]     ph_valid_reg;
    logic [PH_DEPTH-1:0]     ph_valid_next;
    logic signed [COS_W-1:0] cos_c_reg;
    logic signed [COS_W-1:0] cos_m_reg;
    logic signed [30:0]      c_reg;
    logic signed [30:0]      m_reg;
    logic signed [63:0]      s_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic                    clipped_reg;

    logic                    in_acc;
    logic                    out_free;
    logic                    ram_we;
    logic [PH_ADDR_W-1:0]    ram_waddr;
    logic [PH_ADDR_W-1:0]    ram_raddr;
    logic [PHASE_WIDTH-1:0]  ram_wdata;
    logic [PHASE_WIDTH-1:0]  ram_rdata;
    logic [PHASE_WIDTH-1:0]  cur_phase;
    logic [PHASE_WIDTH-1:0]  cur_step;
    logic                    load_car;
    logic                    load_mod;
    logic                    load_mulm;
    logic                    load_muls;
    logic                    load_out;

    logic signed [31:0]      one_m;
    logic signed [62:0]      prod_s;
    logic [15:0]             amp_sum;
    logic signed [63:0]      s_next;
    logic [50:0]             prod_g;
    logic [20:0]             scaled;
    logic [SAMPLE_W-1:0]     sample_next;
    logic                    clipped_next;

    amsg_ram #(
        .WIDTH (PHASE_WIDTH),
        .DEPTH (PH_DEPTH)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_acc   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || smp.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_CAR;
            ST_CAR:   state_next = ST_MOD;
            ST_MOD:   state_next = ST_MULM;
            ST_MULM:  state_next = ST_MULS;
            ST_MULS:  state_next = ST_SCALE;
            ST_SCALE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = PH_CAR;
        ram_raddr = PH_CAR;
        load_car  = 1'b0;
        load_mod  = 1'b0;
        load_mulm = 1'b0;
        load_muls = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                ram_raddr = PH_CAR;
            end
            ST_CAR:
            begin
                ram_raddr = PH_MOD;
                ram_we    = 1'b1;
                ram_waddr = PH_CAR;
                load_car  = 1'b1;
            end
            ST_MOD:
            begin
                ram_raddr = PH_CAR;
                ram_we    = 1'b1;
                ram_waddr = PH_MOD;
                load_mod  = 1'b1;
            end
            ST_MULM:  load_mulm = 1'b1;
            ST_MULS:  load_muls = 1'b1;
            ST_SCALE: load_out  = out_free;
            default:  cmd.ready = 1'b0;
        endcase
    end

    // restart or a never-written entry reads as phase zero
    always_comb
    begin
        cur_phase = ram_rdata;
        if (restart_reg || !ph_valid_reg[ram_waddr])
            cur_phase = '0;
        cur_step      = (ram_waddr == PH_CAR) ? PHASE_WIDTH'(regs.carrier_step)
                                              : PHASE_WIDTH'(regs.mod_step);
        ram_wdata     = cur_phase + cur_step;
        ph_valid_next = ph_valid_reg;
        if (ram_we)
            ph_valid_next[ram_waddr] = 1'b1;
    end

    always_comb
    begin
        one_m   = 32'sd536870912 + 32'(m_reg);
        prod_s  = one_m * c_reg;
        amp_sum = 16'(regs.carrier_amp) + 16'(regs.mod_amp);
        s_next  = {prod_s[62], prod_s} + {4'b0, amp_sum, 44'b0};

        prod_g  = s_reg[62:28] * regs.out_gain;
        scaled  = prod_g[50:30];
        if (s_reg[63])
        begin
            sample_next  = '0;
            clipped_next = 1'b1;
        end
        else if (scaled > 21'(16'hFFFF))
        begin
            sample_next  = '1;
            clipped_next = 1'b1;
        end
        else
        begin
            sample_next  = scaled[SAMPLE_W-1:0];
            clipped_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (smp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_valid_reg  <= ph_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            restart_reg <= cmd.restart;
        if (load_car)
            cos_c_reg <= cos_lookup(cur_phase[PHASE_WIDTH-1 -: COS_ADDR_W]);
        if (load_mod)
        begin
            cos_m_reg <= cos_lookup(cur_phase[PHASE_WIDTH-1 -: COS_ADDR_W]);
            c_reg     <= $signed({1'b0, regs.carrier_amp}) * cos_c_reg;
        end
        if (load_mulm)
            m_reg <= $signed({1'b0, regs.mod_amp}) * cos_m_reg;
        if (load_muls)
            s_reg <= s_next;
        if (load_out)
        begin
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
        end
    end

    assign smp.valid   = out_valid_reg;
    assign smp.sample  = sample_reg;
    assign smp.clipped = clipped_reg;

    `AMSG_ASSERT(a_busy_not_ready, (state_reg != ST_IDLE) |-> !cmd.ready, "ready while busy")
    `AMSG_ASSERT(a_ram_no_collide, ram_we |-> (ram_waddr != ram_raddr), "phase write hits read")
    `AMSG_ASSERT_NEXT(a_acc_starts, in_acc, state_reg == ST_CAR, "item accepted but not started")
    `AMSG_ASSERT_NEXT(a_scale_holds, (state_reg == ST_SCALE) && !out_free, state_reg == ST_SCALE, "result dropped on stall")
endmodule
